// ===== rtl/tts_pkg.sv =====
// ----------------------------------------------------------------------------
// tts_pkg: tick task scheduler shared types
// Item formats, command and status codes, slot entry layout and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

  localparam int MAX_SLOTS_DEF = 16;
  localparam int TICK_MS_DEF   = 10;
  localparam int MAX_RESULTS   = 16;
  localparam int DATA_W        = 24;
  localparam int HANDLE_W      = 8;
  localparam int SLOT_W        = 4;
  localparam int PEND_W        = 8;
  localparam logic [PEND_W-1:0] PEND_MAX = '1;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_ADD  = 2'd1,
    CMD_DEL  = 2'd2,
    CMD_DISP = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_TICK     = 3'd0,
    ST_ADDED    = 3'd1,
    ST_FULL     = 3'd2,
    ST_DELETED  = 3'd3,
    ST_BAD_SLOT = 3'd4,
    ST_RUN      = 3'd5,
    ST_NONE     = 3'd6
  } status_e;

  typedef enum logic {
    RD_IDX   = 1'b0,
    RD_JNEXT = 1'b1
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_TICK  = 2'd0,
    WR_DEC   = 2'd1,
    WR_SHIFT = 2'd2,
    WR_NEW   = 2'd3
  } wr_sel_e;

  typedef enum logic [1:0] {
    SLOT_ZERO  = 2'd0,
    SLOT_INDEX = 2'd1,
    SLOT_COUNT = 2'd2
  } slot_sel_e;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [HANDLE_W-1:0] task_handle;
    logic [DATA_W-1:0]   delay_ms;
    logic [DATA_W-1:0]   period_ms;
    logic [SLOT_W-1:0]   slot_index;
  } in_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [SLOT_W-1:0]   slot;
    logic [HANDLE_W-1:0] run_handle;
    logic                last;
  } out_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [DATA_W-1:0]   countdown;
    logic [DATA_W-1:0]   period;
    logic [PEND_W-1:0]   pending;
  } entry_t;

  typedef struct packed {
    logic      cap_in;
    logic      idx_clr;
    logic      idx_inc;
    logic      j_load_index;
    logic      j_load_idx;
    logic      j_inc;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      rd_en;
    rd_sel_e   rd_sel;
    logic      wr_en;
    wr_sel_e   wr_sel;
    logic      div_start;
    logic      nres_clr;
    logic      hold_clr;
    logic      hold_load;
    logic      push;
    logic      push_hold;
    status_e   push_status;
    slot_sel_e push_slot;
    logic      push_last;
  } ctrl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       idx_end;
    logic       nres_full;
    logic       hold_v;
    logic       add_ok;
    logic       del_ok;
    logic       j_more;
    logic       div_done;
    logic       out_free;
    logic       pending_nz;
    logic       period_z;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/tts_ctrl.sv =====
// ----------------------------------------------------------------------------
// tts_ctrl: scheduler sequencer
// Walks the slot table one entry at a time for tick, delete and dispatch,
// appends the new entry for add, and decides when each result beat is pushed.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire tts_pkg::stat_t st_i,
  output tts_pkg::ctrl_t      ctrl_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_TK_RD  = 4'd2;
  localparam logic [3:0] S_TK_WR  = 4'd3;
  localparam logic [3:0] S_DIV    = 4'd4;
  localparam logic [3:0] S_ADD_WR = 4'd5;
  localparam logic [3:0] S_SH_RD  = 4'd6;
  localparam logic [3:0] S_SH_WR  = 4'd7;
  localparam logic [3:0] S_DS_RD  = 4'd8;
  localparam logic [3:0] S_DS_EX  = 4'd9;
  localparam logic [3:0] S_DS_END = 4'd10;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.cap_in = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (st_i.cmd)
          tts_pkg::CMD_TICK: begin
            ctrl_o.idx_clr = 1'b1;
            state_d = S_TK_RD;
          end
          tts_pkg::CMD_ADD: begin
            if (st_i.add_ok) begin
              ctrl_o.div_start = 1'b1;
              state_d = S_DIV;
            end else if (st_i.out_free) begin
              ctrl_o.push        = 1'b1;
              ctrl_o.push_status = tts_pkg::ST_FULL;
              ctrl_o.push_slot   = tts_pkg::SLOT_ZERO;
              ctrl_o.push_last   = 1'b1;
              state_d = S_IDLE;
            end
          end
          tts_pkg::CMD_DEL: begin
            if (st_i.del_ok) begin
              ctrl_o.j_load_index = 1'b1;
              state_d = S_SH_RD;
            end else if (st_i.out_free) begin
              ctrl_o.push        = 1'b1;
              ctrl_o.push_status = tts_pkg::ST_BAD_SLOT;
              ctrl_o.push_slot   = tts_pkg::SLOT_INDEX;
              ctrl_o.push_last   = 1'b1;
              state_d = S_IDLE;
            end
          end
          tts_pkg::CMD_DISP: begin
            ctrl_o.idx_clr  = 1'b1;
            ctrl_o.nres_clr = 1'b1;
            ctrl_o.hold_clr = 1'b1;
            state_d = S_DS_RD;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_TK_RD: begin
        if (st_i.idx_end) begin
          if (st_i.out_free) begin
            ctrl_o.push        = 1'b1;
            ctrl_o.push_status = tts_pkg::ST_TICK;
            ctrl_o.push_slot   = tts_pkg::SLOT_ZERO;
            ctrl_o.push_last   = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          ctrl_o.rd_en  = 1'b1;
          ctrl_o.rd_sel = tts_pkg::RD_IDX;
          state_d = S_TK_WR;
        end
      end
      S_TK_WR: begin
        ctrl_o.wr_en   = 1'b1;
        ctrl_o.wr_sel  = tts_pkg::WR_TICK;
        ctrl_o.idx_inc = 1'b1;
        state_d = S_TK_RD;
      end
      S_DIV: begin
        if (st_i.div_done) begin
          state_d = S_ADD_WR;
        end
      end
      S_ADD_WR: begin
        if (st_i.out_free) begin
          ctrl_o.wr_en       = 1'b1;
          ctrl_o.wr_sel      = tts_pkg::WR_NEW;
          ctrl_o.cnt_inc     = 1'b1;
          ctrl_o.push        = 1'b1;
          ctrl_o.push_status = tts_pkg::ST_ADDED;
          ctrl_o.push_slot   = tts_pkg::SLOT_COUNT;
          ctrl_o.push_last   = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_SH_RD: begin
        if (st_i.j_more) begin
          ctrl_o.rd_en  = 1'b1;
          ctrl_o.rd_sel = tts_pkg::RD_JNEXT;
          state_d = S_SH_WR;
        end else if (st_i.cmd == tts_pkg::CMD_DEL) begin
          if (st_i.out_free) begin
            ctrl_o.cnt_dec     = 1'b1;
            ctrl_o.push        = 1'b1;
            ctrl_o.push_status = tts_pkg::ST_DELETED;
            ctrl_o.push_slot   = tts_pkg::SLOT_INDEX;
            ctrl_o.push_last   = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          ctrl_o.cnt_dec = 1'b1;
          state_d = S_DS_RD;
        end
      end
      S_SH_WR: begin
        ctrl_o.wr_en  = 1'b1;
        ctrl_o.wr_sel = tts_pkg::WR_SHIFT;
        ctrl_o.j_inc  = 1'b1;
        state_d = S_SH_RD;
      end
      S_DS_RD: begin
        if (st_i.idx_end || st_i.nres_full) begin
          state_d = S_DS_END;
        end else begin
          ctrl_o.rd_en  = 1'b1;
          ctrl_o.rd_sel = tts_pkg::RD_IDX;
          state_d = S_DS_EX;
        end
      end
      S_DS_EX: begin
        if (!st_i.pending_nz) begin
          ctrl_o.idx_inc = 1'b1;
          state_d = S_DS_RD;
        end else if (!st_i.hold_v || st_i.out_free) begin
          // release the previous due task, hold this one
          ctrl_o.push      = st_i.hold_v;
          ctrl_o.push_hold = 1'b1;
          ctrl_o.hold_load = 1'b1;
          if (st_i.period_z) begin
            ctrl_o.j_load_idx = 1'b1;
            state_d = S_SH_RD;
          end else begin
            ctrl_o.wr_en   = 1'b1;
            ctrl_o.wr_sel  = tts_pkg::WR_DEC;
            ctrl_o.idx_inc = 1'b1;
            state_d = S_DS_RD;
          end
        end
      end
      S_DS_END: begin
        if (st_i.out_free) begin
          ctrl_o.push        = 1'b1;
          ctrl_o.push_hold   = st_i.hold_v;
          ctrl_o.push_status = tts_pkg::ST_NONE;
          ctrl_o.push_slot   = tts_pkg::SLOT_ZERO;
          ctrl_o.push_last   = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/tts_dp.sv =====
// ----------------------------------------------------------------------------
// tts_dp: scheduler datapath
// Slot table memory with fill count, walk pointers, reciprocal multiply
// for millisecond to tick conversion, held dispatch beat, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_dp #(
  parameter int MAX_SLOTS = tts_pkg::MAX_SLOTS_DEF,
  parameter int TICK_MS   = tts_pkg::TICK_MS_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire tts_pkg::in_t   in_i,
  input  wire tts_pkg::ctrl_t ctrl_i,
  output tts_pkg::stat_t      st_o,
  output tts_pkg::out_t       out_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i
);

  localparam int IW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW   = $clog2(MAX_SLOTS + 1);
  localparam int CMPW = (CW > tts_pkg::SLOT_W) ? CW : tts_pkg::SLOT_W;
  localparam int NRW  = $clog2(tts_pkg::MAX_RESULTS + 1);
  localparam int DW   = tts_pkg::DATA_W;
  localparam int PW   = 2 * DW + 1;
  localparam int DIV_L = $clog2(TICK_MS);
  localparam int DIV_S = DW + DIV_L;
  localparam longint unsigned DIV_M =
    ((64'd1 << DIV_S) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS);

  tts_pkg::entry_t mem [MAX_SLOTS];
  tts_pkg::entry_t rd_q, wr_data;
  tts_pkg::in_t    item_q;
  tts_pkg::out_t   out_q, push_item;

  logic [CW-1:0]  count_q, idx_q, j_next;
  logic [IW-1:0]  j_q, rd_addr, wr_addr;
  logic [NRW-1:0] nres_q;
  logic           hold_v_q, out_valid_q;
  logic [tts_pkg::SLOT_W-1:0]   hold_slot_q;
  logic [tts_pkg::HANDLE_W-1:0] hold_handle_q;

  logic [DW-1:0]  qd_q, qp_q;
  logic [PW-1:0]  prod_d, prod_p;

  logic out_free;

  assign j_next   = CW'(j_q) + CW'(1);
  assign out_free = !out_valid_q || out_ready_i;

  // status toward the sequencer
  always_comb begin
    st_o.cmd        = item_q.cmd;
    st_o.idx_end    = idx_q >= count_q;
    st_o.nres_full  = nres_q == NRW'(tts_pkg::MAX_RESULTS);
    st_o.hold_v     = hold_v_q;
    st_o.add_ok     = (item_q.task_handle != '0) && (count_q != CW'(MAX_SLOTS));
    st_o.del_ok     = CMPW'(item_q.slot_index) < CMPW'(count_q);
    st_o.j_more     = j_next < count_q;
    st_o.div_done   = 1'b1;
    st_o.out_free   = out_free;
    st_o.pending_nz = rd_q.pending != '0;
    st_o.period_z   = rd_q.period == '0;
  end

  // slot table
  always_comb begin
    unique case (ctrl_i.rd_sel)
      tts_pkg::RD_IDX:   rd_addr = idx_q[IW-1:0];
      tts_pkg::RD_JNEXT: rd_addr = j_next[IW-1:0];
      default:           rd_addr = idx_q[IW-1:0];
    endcase
  end

  always_comb begin
    wr_data = rd_q;
    wr_addr = idx_q[IW-1:0];
    unique case (ctrl_i.wr_sel)
      tts_pkg::WR_TICK: begin
        if (rd_q.countdown != '0) begin
          wr_data.countdown = rd_q.countdown - DW'(1);
        end else begin
          wr_data.countdown = rd_q.period;
          if (rd_q.pending != tts_pkg::PEND_MAX) begin
            wr_data.pending = rd_q.pending + tts_pkg::PEND_W'(1);
          end
        end
      end
      tts_pkg::WR_DEC: begin
        wr_data.pending = rd_q.pending - tts_pkg::PEND_W'(1);
      end
      tts_pkg::WR_SHIFT: begin
        wr_addr = j_q;
      end
      tts_pkg::WR_NEW: begin
        wr_addr           = count_q[IW-1:0];
        wr_data.handle    = item_q.task_handle;
        wr_data.countdown = qd_q;
        wr_data.period    = qp_q;
        wr_data.pending   = '0;
      end
      default: wr_data = rd_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl_i.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // divide by the tick length: multiply by the rounded-up reciprocal, exact for DW-bit input
  assign prod_d = PW'(item_q.delay_ms) * PW'(DIV_M);
  assign prod_p = PW'(item_q.period_ms) * PW'(DIV_M);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap_in) begin
      item_q <= in_i;
    end
    if (ctrl_i.div_start) begin
      qd_q <= DW'(prod_d >> DIV_S);
      qp_q <= DW'(prod_p >> DIV_S);
    end
    if (ctrl_i.hold_load) begin
      hold_slot_q   <= tts_pkg::SLOT_W'(idx_q);
      hold_handle_q <= rd_q.handle;
    end
    if (ctrl_i.push) begin
      out_q <= push_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      j_q         <= '0;
      nres_q      <= '0;
      hold_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.cnt_inc) begin
        count_q <= count_q + CW'(1);
      end else if (ctrl_i.cnt_dec) begin
        count_q <= count_q - CW'(1);
      end
      if (ctrl_i.idx_clr) begin
        idx_q <= '0;
      end else if (ctrl_i.idx_inc) begin
        idx_q <= idx_q + CW'(1);
      end
      if (ctrl_i.j_load_index) begin
        j_q <= IW'(item_q.slot_index);
      end else if (ctrl_i.j_load_idx) begin
        j_q <= idx_q[IW-1:0];
      end else if (ctrl_i.j_inc) begin
        j_q <= j_q + IW'(1);
      end
      if (ctrl_i.nres_clr) begin
        nres_q <= '0;
      end else if (ctrl_i.hold_load) begin
        nres_q <= nres_q + NRW'(1);
      end
      if (ctrl_i.hold_clr) begin
        hold_v_q <= 1'b0;
      end else if (ctrl_i.hold_load) begin
        hold_v_q <= 1'b1;
      end
      if (ctrl_i.push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result beat
  always_comb begin
    push_item.last = ctrl_i.push_last;
    if (ctrl_i.push_hold) begin
      push_item.status     = tts_pkg::ST_RUN;
      push_item.slot       = hold_slot_q;
      push_item.run_handle = hold_handle_q;
    end else begin
      push_item.status     = ctrl_i.push_status;
      push_item.run_handle = '0;
      unique case (ctrl_i.push_slot)
        tts_pkg::SLOT_ZERO:  push_item.slot = '0;
        tts_pkg::SLOT_INDEX: push_item.slot = item_q.slot_index;
        tts_pkg::SLOT_COUNT: push_item.slot = tts_pkg::SLOT_W'(count_q);
        default:             push_item.slot = '0;
      endcase
    end
  end

  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/tick_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// tick_task_scheduler: time-triggered cooperative task scheduler
// N slots in use: tick visits all N, add writes slot N, refused add or bad delete answers
// from decode; delete of slot k shifts later slots down; dispatch visits slots in order;
// result stalls add their wait; next command taken in the cycle after the last push.
// Reset: asynchronous; table empty (fill count zero), idle, no result beat pending.
// ----------------------------------------------------------------------------
`default_nettype none

module tick_task_scheduler #(
  parameter int MAX_SLOTS = tts_pkg::MAX_SLOTS_DEF,
  parameter int TICK_MS   = tts_pkg::TICK_MS_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire tts_pkg::in_t in_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output tts_pkg::out_t     out_o
);

  tts_pkg::ctrl_t ctrl;
  tts_pkg::stat_t stat;

  tts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (stat),
    .ctrl_o     (ctrl)
  );

  tts_dp #(
    .MAX_SLOTS (MAX_SLOTS),
    .TICK_MS   (TICK_MS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .ctrl_i      (ctrl),
    .st_o        (stat),
    .out_o       (out_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

endmodule

`default_nettype wire

// ===== rtl/tts_checker.sv =====
// ----------------------------------------------------------------------------
// tts_checker: port-level checks for the scheduler
// Result beat field rules and command handshake behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_port_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_ready_o,
  input wire tts_pkg::in_t  in_i,
  input wire logic          out_valid_o,
  input wire logic          out_ready_i,
  input wire tts_pkg::out_t out_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("result beat changed while stalled");

  a_handle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.status != tts_pkg::ST_RUN) |-> out_o.run_handle == '0)
    else $error("run handle set on a non-run beat");

  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.status == tts_pkg::ST_TICK || out_o.status == tts_pkg::ST_FULL ||
                    out_o.status == tts_pkg::ST_NONE) |-> out_o.slot == '0)
    else $error("slot set on a slotless beat");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.status != tts_pkg::ST_RUN) |-> out_o.last)
    else $error("single-beat result without last");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second command taken while one is in flight");

endmodule

bind tick_task_scheduler tts_port_checker u_tts_checker (.*);

`default_nettype wire

// ===== dv/tts_checker.sv =====
// ----------------------------------------------------------------------------
// tts_checker: result checker for the tick task scheduler
// Watches the command and result channels. Every accepted command updates a
// private copy of the slot table and queues the result beats it must cause;
// every accepted result beat is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module tts_checker
  import tts_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF,
  parameter int TICK_MS   = TICK_MS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  logic cmd_ready_i,
  input  in_t  cmd_i,
  input  logic res_valid_i,
  input  logic res_ready_i,
  input  out_t res_i,
  output int   fail_cnt_o,
  output int   owed_cnt_o,
  output int   checked_o,
  output int   runs_o,
  output int   rejects_o
);

  entry_t slots [MAX_SLOTS];
  out_t   owed_q [$];
  out_t   want;

  function automatic out_t make_beat(status_e st, int slot, logic [HANDLE_W-1:0] h);
    out_t r;
    r.status     = st;
    r.slot       = slot[SLOT_W-1:0];
    r.run_handle = h;
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic void shift_down(int s);
    for (int j = s; j + 1 < MAX_SLOTS; j++) begin
      slots[j] = slots[j+1];
    end
    slots[MAX_SLOTS-1] = '0;
  endfunction

  function automatic void schedule_step(in_t c);
    out_t beats [$];
    int   free_idx;
    int   i;
    case (cmd_e'(c.cmd))
      CMD_TICK: begin
        foreach (slots[k]) begin
          if (slots[k].handle != '0) begin
            if (slots[k].countdown != '0) begin
              slots[k].countdown--;
            end else begin
              slots[k].countdown = slots[k].period;
              if (slots[k].pending != PEND_MAX) slots[k].pending++;
            end
          end
        end
        beats.push_back(make_beat(ST_TICK, 0, '0));
      end
      CMD_ADD: begin
        free_idx = MAX_SLOTS;
        for (int k = MAX_SLOTS - 1; k >= 0; k--) begin
          if (slots[k].handle == '0) free_idx = k;
        end
        if (c.task_handle == '0 || free_idx == MAX_SLOTS) begin
          beats.push_back(make_beat(ST_FULL, 0, '0));
          rejects_o++;
        end else begin
          slots[free_idx].handle    = c.task_handle;
          slots[free_idx].countdown = c.delay_ms / TICK_MS;
          slots[free_idx].period    = c.period_ms / TICK_MS;
          slots[free_idx].pending   = '0;
          beats.push_back(make_beat(ST_ADDED, free_idx, '0));
        end
      end
      CMD_DEL: begin
        if (int'(c.slot_index) >= MAX_SLOTS || slots[c.slot_index].handle == '0) begin
          beats.push_back(make_beat(ST_BAD_SLOT, c.slot_index, '0));
        end else begin
          shift_down(c.slot_index);
          beats.push_back(make_beat(ST_DELETED, c.slot_index, '0));
        end
      end
      default: begin
        i = 0;
        while (i < MAX_SLOTS && beats.size() < MAX_RESULTS) begin
          if (slots[i].handle != '0 && slots[i].pending != '0) begin
            slots[i].pending--;
            beats.push_back(make_beat(ST_RUN, i, slots[i].handle));
            runs_o++;
            if (slots[i].period == '0) begin
              shift_down(i);
              continue;
            end
          end
          i++;
        end
        if (beats.size() == 0) beats.push_back(make_beat(ST_NONE, 0, '0));
      end
    endcase
    beats[beats.size()-1].last = 1'b1;
    foreach (beats[k]) owed_q.push_back(beats[k]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (slots[k]) slots[k] = '0;
      owed_q.delete();
      fail_cnt_o = 0;
      checked_o  = 0;
      runs_o     = 0;
      rejects_o  = 0;
    end else begin
      if (cmd_valid_i && cmd_ready_i) schedule_step(cmd_i);
      if (res_valid_i && res_ready_i) begin
        if (owed_q.size() == 0) begin
          if (fail_cnt_o < 10) begin
            $display("unexpected result beat: status %0d slot %0d handle %0d last %0d",
                     res_i.status, res_i.slot, res_i.run_handle, res_i.last);
          end
          fail_cnt_o++;
        end else begin
          want = owed_q.pop_front();
          if (res_i.status !== want.status || res_i.slot !== want.slot ||
              res_i.run_handle !== want.run_handle || res_i.last !== want.last) begin
            if (fail_cnt_o < 10) begin
              $display("beat %0d mismatch (exp/got): status %0d/%0d slot %0d/%0d",
                       checked_o, want.status, res_i.status, want.slot, res_i.slot);
              $display("  handle %0d/%0d last %0d/%0d",
                       want.run_handle, res_i.run_handle, want.last, res_i.last);
            end
            fail_cnt_o++;
          end
        end
        checked_o++;
      end
    end
    owed_cnt_o = owed_q.size();
  end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: tick task scheduler top-level test
// Drives scheduler commands with random gaps and result back-pressure: a
// directed pass over the corner cases, random command mixes and a tick run
// that stacks up pending runs. Checking is done by tts_checker.
// ----------------------------------------------------------------------------
module testbench;
  import tts_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_beat;
  logic out_valid;
  logic out_ready;
  out_t out_beat;

  int fail_cnt;
  int owed_cnt;
  int checked;
  int runs;
  int rejects;
  int sent;
  int cycles;
  bit quiet;

  tick_task_scheduler u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_beat),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_beat)
  );

  tts_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cmd_valid_i (in_valid),
    .cmd_ready_i (in_ready),
    .cmd_i       (in_beat),
    .res_valid_i (out_valid),
    .res_ready_i (out_ready),
    .res_i       (out_beat),
    .fail_cnt_o  (fail_cnt),
    .owed_cnt_o  (owed_cnt),
    .checked_o   (checked),
    .runs_o      (runs),
    .rejects_o   (rejects)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d beats still owed", cycles, owed_cnt);
    $display("FAIL");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic cmd_e pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return CMD_TICK;
    if (r < 57) return CMD_ADD;
    if (r < 77) return CMD_DEL;
    return CMD_DISP;
  endfunction

  function automatic in_t random_cmd(cmd_e c);
    in_t b;
    int  r;
    b.cmd         = c;
    b.task_handle = ($urandom_range(0, 11) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    r = $urandom_range(0, 99);
    b.delay_ms    = (r < 80) ? 24'($urandom_range(0, 60)) : 24'($urandom_range(0, 24'hFFFFFF));
    r = $urandom_range(0, 99);
    if (r < 25) b.period_ms = 24'($urandom_range(0, 9));
    else if (r < 80) b.period_ms = 24'($urandom_range(10, 90));
    else b.period_ms = 24'($urandom_range(0, 24'hFFFFFF));
    b.slot_index  = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 4)) :
                                                  4'($urandom_range(0, 15));
    return b;
  endfunction

  function automatic in_t beat_of(cmd_e c, logic [7:0] h, logic [23:0] d, logic [23:0] p,
                                  logic [3:0] s);
    in_t b;
    b.cmd         = c;
    b.task_handle = h;
    b.delay_ms    = d;
    b.period_ms   = p;
    b.slot_index  = s;
    return b;
  endfunction

  task automatic send(in_t b);
    @(negedge clk);
    in_valid <= 1'b1;
    in_beat  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic idle(int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic push(in_t b);
    send(b);
    idle(gap_len());
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (owed_cnt != 0) @(negedge clk);
  endtask

  initial begin
    int n;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_ready <= 1'b1;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      n = gap_len();
      if (n > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  initial begin
    in_valid = 1'b0;
    in_beat  = '0;
    rst_n    = 1'b0;
    quiet    = 1'b0;
    sent     = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    push(beat_of(CMD_DISP, 8'd0, 24'd0, 24'd0, 4'd0));
    push(beat_of(CMD_TICK, 8'd0, 24'd0, 24'd0, 4'd0));
    push(beat_of(CMD_ADD, 8'd0, 24'd50, 24'd50, 4'd0));
    push(beat_of(CMD_ADD, 8'hFF, 24'hFFFFFF, 24'hFFFFFF, 4'hF));
    push(beat_of(CMD_ADD, 8'd1, 24'd0, 24'd0, 4'd0));
    push(beat_of(CMD_ADD, 8'd2, 24'd9, 24'd19, 4'd0));
    push(beat_of(CMD_DEL, 8'd0, 24'd0, 24'd0, 4'd15));
    push(beat_of(CMD_TICK, 8'd0, 24'd0, 24'd0, 4'd0));
    push(beat_of(CMD_DISP, 8'd0, 24'd0, 24'd0, 4'd0));
    push(beat_of(CMD_DEL, 8'd0, 24'd0, 24'd0, 4'd0));
    for (int k = 0; k < 15; k++) begin
      push(beat_of(CMD_ADD, 8'($urandom_range(1, 255)), 24'($urandom_range(0, 40)),
                   24'($urandom_range(0, 60)), 4'd0));
    end
    push(beat_of(CMD_ADD, 8'd77, 24'd0, 24'd10, 4'd0));

    for (int ph = 0; ph < 5; ph++) begin
      quiet = (ph == 2);
      if (ph == 3) drain();
      repeat (36) push(random_cmd(pick_cmd()));
    end

    drain();
    quiet = 1'b1;
    repeat (3) push(beat_of(CMD_DEL, 8'd0, 24'd0, 24'd0, 4'd0));
    push(beat_of(CMD_ADD, 8'hA5, 24'd0, 24'd0, 4'd0));
    repeat (40) push(random_cmd(CMD_TICK));
    quiet = 1'b0;
    repeat (2) push(random_cmd(CMD_DISP));

    drain();
    repeat (64) @(negedge clk);
    $display("%0d commands sent, %0d result beats checked, %0d task runs, %0d adds refused",
             sent, checked, runs, rejects);
    $display("covered directed corners, random mixes, a full table and stacked pending runs");
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tts_pkg.sv
rtl/tts_ctrl.sv
rtl/tts_dp.sv
rtl/tick_task_scheduler.sv
rtl/tts_checker.sv
dv/tts_checker.sv
dv/testbench.sv
